[design/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

[design/dfd_pkg.sv]
`timescale 1ns / 1ps
package dfd_pkg;
    localparam int unsigned CoordW = 16;
    localparam int unsigned SqW    = 33;
    localparam int unsigned CellW  = 34;
    localparam int unsigned RootW  = 17;
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_DROP  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // One command from the front to the back.
    typedef struct packed {
        logic              is_b;
        logic              last;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
    } cmd_t;
endpackage

[design/dfd_ram.sv]
`timescale 1ns / 1ps
module dfd_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end
    assign rdata = rdata_reg;
endmodule

[design/dfd_queue.sv]
`timescale 1ns / 1ps
module dfd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  dfd_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output dfd_pkg::cmd_t out_cmd
);
    import dfd_pkg::*;
    cmd_t       slot_reg [2];
    logic       wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = slot_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Two-entry queue pointers.
    always_comb begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= in_cmd;
        end
    end
endmodule

[design/dfd_back.sv]
`timescale 1ns / 1ps
module dfd_back #(
    parameter int unsigned MAX_POINTS = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  dfd_pkg::cmd_t            cmd,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [dfd_pkg::RootW-1:0] m_distance_root,
    output logic [dfd_pkg::SqW-1:0]   m_squared_distance,
    output logic [1:0]               m_status
);
    import dfd_pkg::*;
    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_DIF  = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_CELL = 7'b0010000,
        S_SQRT = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_a_reg, cnt_b_reg;
    logic              ovf_reg;
    logic [AW-1:0]     i_reg, j_reg;
    logic [CellW-1:0]  diag_reg, left_reg, d_reg;
    logic signed [CoordW:0] dx_reg, dy_reg;
    logic [SqW-1:0]    sq_reg;
    logic [1:0]        status_reg;
    logic [CellW-1:0]  rem_reg, res_reg, bit_reg;
    logic              out_valid_reg;
    logic [RootW-1:0]  out_root_reg;
    logic [SqW-1:0]    out_sq_reg;
    logic [1:0]        out_status_reg;

    logic              a_we, b_we, t_we;
    logic [CoordW-1:0] ax, ay, bx, by;
    logic [CellW-1:0]  up, cell_val;
    logic [AW-1:0]     t_raddr;
    logic [CoordW-1:0] ux, uy;
    logic [2*CoordW-1:0] px, py;

    // Point stores and the one-row dynamic programming table.
    assign a_we = (state_reg == S_IDLE) && cmd_valid && !cmd.is_b
        && (cnt_a_reg < CW'(MAX_POINTS));
    assign b_we = (state_reg == S_IDLE) && cmd_valid && cmd.is_b
        && (cnt_b_reg < CW'(MAX_POINTS));
    assign t_we = (state_reg == S_CELL);
    assign t_raddr = j_reg;

    dfd_ram #(.WIDTH(CoordW), .DEPTH(MAX_POINTS)) u_ax (.aclk, .we(a_we),
        .waddr(cnt_a_reg[AW-1:0]), .wdata(cmd.x), .raddr(i_reg), .rdata(ax));
    dfd_ram #(.WIDTH(CoordW), .DEPTH(MAX_POINTS)) u_ay (.aclk, .we(a_we),
        .waddr(cnt_a_reg[AW-1:0]), .wdata(cmd.y), .raddr(i_reg), .rdata(ay));
    dfd_ram #(.WIDTH(CoordW), .DEPTH(MAX_POINTS)) u_bx (.aclk, .we(b_we),
        .waddr(cnt_b_reg[AW-1:0]), .wdata(cmd.x), .raddr(j_reg), .rdata(bx));
    dfd_ram #(.WIDTH(CoordW), .DEPTH(MAX_POINTS)) u_by (.aclk, .we(b_we),
        .waddr(cnt_b_reg[AW-1:0]), .wdata(cmd.y), .raddr(j_reg), .rdata(by));
    dfd_ram #(.WIDTH(CellW), .DEPTH(MAX_POINTS)) u_tab (.aclk, .we(t_we),
        .waddr(j_reg), .wdata(cell_val), .raddr(t_raddr), .rdata(up));

    // Coordinate difference magnitudes and their squares.
    assign ux = CoordW'(dx_reg[CoordW] ? -dx_reg : dx_reg);
    assign uy = CoordW'(dy_reg[CoordW] ? -dy_reg : dy_reg);
    assign px = ux * ux;
    assign py = uy * uy;

    // Cell value from its predecessors.
    always_comb begin
        logic [CellW-1:0] m;
        m = up;
        if (i_reg == '0 && j_reg == '0) begin
            m = '0;
        end else if (i_reg == '0) begin
            m = left_reg;
        end else if (j_reg != '0) begin
            if (diag_reg < m) m = diag_reg;
            if (left_reg < m) m = left_reg;
        end
        cell_val = (m > d_reg) ? m : d_reg;
    end

    assign cmd_ready = (state_reg == S_IDLE) && !(cmd.is_b && cmd.last && out_valid_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid && cmd_ready && cmd.is_b && cmd.last) begin
                    if (cnt_a_reg == '0) state_next = S_OUT;
                    else state_next = S_RD;
                end
            end
            S_RD:   state_next = S_DIF;
            S_DIF:  state_next = S_MUL;
            S_MUL:  state_next = S_CELL;
            S_CELL: begin
                if (CW'(j_reg) + CW'(1) == cnt_b_reg && CW'(i_reg) + CW'(1) == cnt_a_reg)
                    state_next = S_SQRT;
                else
                    state_next = S_RD;
            end
            S_SQRT: if (bit_reg == '0) state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid && m_ready) out_valid_reg <= 1'b0;
            if (state_reg == S_IDLE && cmd_valid && cmd_ready) begin
                if (a_we) cnt_a_reg <= cnt_a_reg + CW'(1);
                if (b_we) cnt_b_reg <= cnt_b_reg + CW'(1);
                if (!a_we && !b_we) ovf_reg <= 1'b1;
            end
            if (state_reg == S_OUT) begin
                out_valid_reg <= 1'b1;
                cnt_a_reg     <= '0;
                cnt_b_reg     <= '0;
                ovf_reg       <= 1'b0;
            end
        end
    end

    // Datapath: indices, distance, table walk and bitwise square root.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                i_reg <= '0;
                j_reg <= '0;
                status_reg <= (ovf_reg || !(a_we || b_we)) ? STATUS_DROP : STATUS_OK;
                sq_reg <= '0;
                if (cnt_a_reg == '0) status_reg <= STATUS_EMPTY;
            end
            S_RD: ;
            S_DIF: begin
                dx_reg <= $signed({ax[CoordW-1], ax}) - $signed({bx[CoordW-1], bx});
                dy_reg <= $signed({ay[CoordW-1], ay}) - $signed({by[CoordW-1], by});
            end
            S_MUL: begin
                d_reg <= CellW'(px) + CellW'(py);
            end
            S_CELL: ;
            default: ;
        endcase
        if (state_reg == S_CELL) begin
            diag_reg <= up;
            left_reg <= cell_val;
            if (CW'(j_reg) + CW'(1) == cnt_b_reg) begin
                j_reg <= '0;
                i_reg <= i_reg + AW'(1);
            end else begin
                j_reg <= j_reg + AW'(1);
            end
            sq_reg  <= SqW'(cell_val);
            rem_reg <= cell_val;
            res_reg <= '0;
            bit_reg <= CellW'(1) << (CellW - 2);
        end
        if (state_reg == S_SQRT && bit_reg != '0) begin
            if (rem_reg >= res_reg + bit_reg) begin
                rem_reg <= rem_reg - (res_reg + bit_reg);
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (state_reg == S_IDLE) res_reg <= '0;
        // The result is held here while the next pair loads.
        if (state_reg == S_OUT) begin
            out_root_reg   <= res_reg[RootW-1:0];
            out_sq_reg     <= sq_reg;
            out_status_reg <= status_reg;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_distance_root    = out_root_reg;
    assign m_squared_distance = out_sq_reg;
    assign m_status           = out_status_reg;
endmodule

[design/dfd_front.sv]
`timescale 1ns / 1ps
module dfd_front (
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [dfd_pkg::CoordW-1:0]  s_x_coord,
    input  logic [dfd_pkg::CoordW-1:0]  s_y_coord,
    input  logic                        s_last_point,
    output logic                        q_valid,
    input  logic                        q_ready,
    output dfd_pkg::cmd_t               q_cmd
);
    import dfd_pkg::*;
    // Classify the beat into a command; A markers drop their last flag.
    always_comb begin
        q_cmd.is_b = s_req_type;
        q_cmd.last = s_last_point && s_req_type;
        q_cmd.x    = s_x_coord;
        q_cmd.y    = s_y_coord;
    end
    assign q_valid = s_valid;
    assign s_ready = q_ready;
endmodule

[design/discrete_frechet_distance_unit.sv]
`timescale 1ns / 1ps
// Discrete Frechet distance unit.
// Input channel s_*: one beat per point, curve A first (s_req_type = 0),
// then curve B (s_req_type = 1); s_last_point on a B point closes the pair.
// Output channel m_*: one beat per pair with the squared distance (Q17.16),
// its floor square root (Q9.8) and a status code.
// Loading takes one point per cycle through a two-entry command queue
// while the back end is idle. Unless curve A is empty, the closing point
// starts a walk over count_a * count_b cells, one at a time, each through
// store read, difference, square, cell update, then a 17-step square root.
// The cell loop through the point and row memories sets the run time.
// Reset clears counters and the overflow flag; stores need no clearing.
// While the result waits on m_ready, points keep loading; the next closing
// point waits until the previous result is taken.
module discrete_frechet_distance_unit #(
    parameter int unsigned MAX_POINTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic signed [15:0] s_x_coord,
    input  logic signed [15:0] s_y_coord,
    input  logic        s_last_point,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [16:0] m_distance_root,
    output logic [32:0] m_squared_distance,
    output logic [1:0]  m_status
);
    import dfd_pkg::*;
    cmd_t f_cmd, b_cmd;
    logic f_valid, f_ready, b_valid, b_ready;

    dfd_front u_front (.s_valid, .s_ready, .s_req_type, .s_x_coord(s_x_coord),
        .s_y_coord(s_y_coord), .s_last_point, .q_valid(f_valid), .q_ready(f_ready),
        .q_cmd(f_cmd));
    dfd_queue u_queue (.aclk, .aresetn, .in_valid(f_valid), .in_ready(f_ready),
        .in_cmd(f_cmd), .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd));
    dfd_back #(.MAX_POINTS(MAX_POINTS)) u_back (.aclk, .aresetn, .cmd_valid(b_valid),
        .cmd_ready(b_ready), .cmd(b_cmd), .m_valid, .m_ready, .m_distance_root,
        .m_squared_distance, .m_status);
endmodule

[design/dfd_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [16:0] m_distance_root,
    input logic [32:0] m_squared_distance,
    input logic [1:0]  m_status
);
    import dfd_pkg::*;
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_squared_distance), "result changed while stalled")
    `ASSERT_IMPL(a_stat, aclk, aresetn, m_valid, m_status <= STATUS_EMPTY,
        "bad status code")
    `ASSERT_IMPL(a_empty, aclk, aresetn, m_valid && m_status == STATUS_EMPTY,
        m_squared_distance == 33'd0 && m_distance_root == 17'd0, "empty result not zero")
    `ASSERT_IMPL(a_root, aclk, aresetn, m_valid,
        ({17'd0, m_distance_root} * {17'd0, m_distance_root}) <= {1'b0, m_squared_distance},
        "root too large")
endmodule
bind discrete_frechet_distance_unit dfd_checker u_chk (.aclk, .aresetn, .m_valid, .m_ready,
    .m_distance_root, .m_squared_distance, .m_status);

[bench/tb_discrete_frechet_distance_unit.sv]
`timescale 1ns / 1ps
module tb_discrete_frechet_distance_unit;
    import dfd_pkg::*;

    localparam int unsigned CAPACITY   = 64;
    localparam int          CYCLE_CAP  = 4000000;
    localparam logic        CURVE_A    = 1'b0;
    localparam logic        CURVE_B    = 1'b1;

    typedef struct {
        logic [RootW-1:0] root;
        logic [SqW-1:0]   sq;
        logic [1:0]       status;
    } frechet_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_req_type = 1'b0;
    logic signed [15:0] s_x_coord = '0;
    logic signed [15:0] s_y_coord = '0;
    logic s_last_point = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [16:0] m_distance_root;
    logic [32:0] m_squared_distance;
    logic [1:0] m_status;

    discrete_frechet_distance_unit #(.MAX_POINTS(CAPACITY)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_x_coord(s_x_coord), .s_y_coord(s_y_coord), .s_last_point(s_last_point),
        .m_valid(m_valid), .m_ready(m_ready), .m_distance_root(m_distance_root),
        .m_squared_distance(m_squared_distance), .m_status(m_status)
    );

    // Shadow copy of the loaded curves.
    logic signed [15:0] shadow_ax [CAPACITY];
    logic signed [15:0] shadow_ay [CAPACITY];
    logic signed [15:0] shadow_bx [CAPACITY];
    logic signed [15:0] shadow_by [CAPACITY];
    int unsigned shadow_na = 0;
    int unsigned shadow_nb = 0;
    bit shadow_dropped = 1'b0;

    frechet_result_t pending_distances[$];
    int errors = 0;
    int points_sent = 0;
    int pairs_checked = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic recv_hold = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver readiness: random stalls, or a forced hold-off.
    always @(posedge aclk) begin
        if (recv_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Squared distance between a kept A point and a kept B point.
    function automatic longint unsigned pair_dist2(int unsigned i, int unsigned j);
        longint signed dx, dy;
        dx = longint'(shadow_ax[i]) - longint'(shadow_bx[j]);
        dy = longint'(shadow_ay[i]) - longint'(shadow_by[j]);
        return longint'(dx * dx + dy * dy);
    endfunction

    // Walk the coupling table row by row and return the final cell.
    function automatic longint unsigned coupling_value();
        longint unsigned row [CAPACITY];
        longint unsigned diag, up, d, best, cell_v;
        for (int unsigned i = 0; i < shadow_na; i++) begin
            diag = 0;
            for (int unsigned j = 0; j < shadow_nb; j++) begin
                d = pair_dist2(i, j);
                up = row[j];
                if (i == 0 && j == 0) begin
                    cell_v = d;
                end else if (i == 0) begin
                    cell_v = (row[j-1] > d) ? row[j-1] : d;
                end else if (j == 0) begin
                    cell_v = (up > d) ? up : d;
                end else begin
                    best = (up < diag) ? up : diag;
                    best = (best < row[j-1]) ? best : row[j-1];
                    cell_v = (best > d) ? best : d;
                end
                diag = up;
                row[j] = cell_v;
            end
        end
        return row[shadow_nb-1];
    endfunction

    // Floor square root by setting result bits from the top down.
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r, t;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // Update the shadow state for one accepted point.
    task automatic track_point(logic req, logic signed [15:0] x, logic signed [15:0] y,
                               logic last);
        frechet_result_t exp_r;
        longint unsigned sq;
        if (req == CURVE_A) begin
            if (shadow_na < CAPACITY) begin
                shadow_ax[shadow_na] = x;
                shadow_ay[shadow_na] = y;
                shadow_na++;
            end else begin
                shadow_dropped = 1'b1;
            end
        end else begin
            if (shadow_nb < CAPACITY) begin
                shadow_bx[shadow_nb] = x;
                shadow_by[shadow_nb] = y;
                shadow_nb++;
            end else begin
                shadow_dropped = 1'b1;
            end
            if (last) begin
                if (shadow_na == 0 || shadow_nb == 0) begin
                    sq = 0;
                    exp_r.status = STATUS_EMPTY;
                end else begin
                    sq = coupling_value();
                    exp_r.status = shadow_dropped ? STATUS_DROP : STATUS_OK;
                end
                exp_r.sq = sq[SqW-1:0];
                exp_r.root = RootW'(floor_root(sq));
                pending_distances.insert(pending_distances.size(), exp_r);
                shadow_na = 0;
                shadow_nb = 0;
                shadow_dropped = 1'b0;
            end
        end
    endtask

    // Offer one point and wait for its beat.
    task automatic send_point(logic req, logic signed [15:0] x, logic signed [15:0] y,
                              logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_x_coord <= x;
        s_y_coord <= y;
        s_last_point <= last;
        do @(posedge aclk); while (!s_ready);
        points_sent++;
        track_point(req, x, y, last);
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // One pair of curves with random points; stray A points may fall inside B.
    task automatic send_pair(int na, int nb, bit stray);
        for (int i = 0; i < na; i++) send_point(CURVE_A, rand_coord(), rand_coord(), i == na-1);
        for (int j = 0; j < nb; j++) begin
            if (stray && $urandom_range(3) == 0)
                send_point(CURVE_A, rand_coord(), rand_coord(), $urandom_range(1));
            send_point(CURVE_B, rand_coord(), rand_coord(), j == nb-1);
        end
    endtask

    // Compare each result beat with the oldest prediction.
    always @(posedge aclk) begin
        frechet_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_distances.size() == 0) begin
                $display("%0t: unexpected result root=%0d sq=%0d status=%0d", $time,
                         m_distance_root, m_squared_distance, m_status);
                errors++;
            end else begin
                e = pending_distances.pop_front();
                pairs_checked++;
                if (m_squared_distance !== e.sq) begin
                    $display("%0t: squared_distance expected %0d got %0d", $time,
                             e.sq, m_squared_distance);
                    errors++;
                end
                if (m_distance_root !== e.root) begin
                    $display("%0t: distance_root expected %0d got %0d", $time,
                             e.root, m_distance_root);
                    errors++;
                end
                if (m_status !== e.status) begin
                    $display("%0t: status expected %0d got %0d", $time, e.status, m_status);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        // Single points at opposite corners give the largest distance.
        send_point(CURVE_A, 16'sh8000, 16'sh8000, 1'b1);
        send_point(CURVE_B, 16'sh7fff, 16'sh7fff, 1'b1);
        send_point(CURVE_A, 16'sh7fff, 16'sh8000, 1'b0);
        send_point(CURVE_B, 16'sh7fff, 16'sh8000, 1'b1);
        // Empty curve A.
        send_point(CURVE_B, 16'sh0100, 16'sh0200, 1'b1);
        // Marker on A only, then B with an A point appended mid-way.
        send_point(CURVE_A, 16'sh0000, 16'sh0000, 1'b1);
        send_point(CURVE_B, 16'sh0300, 16'sh0000, 1'b0);
        send_point(CURVE_A, 16'sh0400, 16'sh0400, 1'b1);
        send_point(CURVE_B, 16'shff00, 16'sh0100, 1'b1);
        // Full-size pair, then a pair past capacity on both curves.
        send_pair(CAPACITY, CAPACITY, 1'b0);
        send_pair(CAPACITY + 2, CAPACITY + 3, 1'b0);
        // Overflow on B alone while A is empty: empty wins.
        send_pair(0, CAPACITY + 1, 1'b0);
    endtask

    task automatic test_random(int target);
        int start, na, nb;
        start = points_sent;
        while (points_sent - start < target) begin
            if ($urandom_range(199) == 0) begin
                na = $urandom_range(CAPACITY + 2, 30);
                nb = $urandom_range(CAPACITY + 2, 30);
            end else begin
                na = $urandom_range(6);
                nb = $urandom_range(6, 1);
            end
            send_pair(na, nb, $urandom_range(4) == 0);
        end
    endtask

    // Hold the receiver off while pairs keep coming, so the input stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                recv_hold <= 1'b1;
                repeat (3000) @(posedge aclk);
                recv_hold <= 1'b0;
            end
            for (int k = 0; k < 12; k++) send_pair($urandom_range(3, 1), $urandom_range(3, 1), 0);
        join
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(280);
        send_idle_pct = 49; recv_stall_pct = 0;  test_random(280);
        send_idle_pct = 0;  recv_stall_pct = 49; test_random(280);
        send_idle_pct = 21; recv_stall_pct = 21; test_random(230);
        test_backpressure();
        s_valid <= 1'b0;
        while (pending_distances.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Sent %0d points and checked %0d distance results,", points_sent,
                 pairs_checked);
        $display("covering corner coordinates, empty curves, capacity drops and stalls.");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+design
design/dfd_pkg.sv
design/dfd_ram.sv
design/dfd_queue.sv
design/dfd_back.sv
design/dfd_front.sv
design/discrete_frechet_distance_unit.sv
design/dfd_checker.sv
bench/tb_discrete_frechet_distance_unit.sv
